// ===== rtl/gasp_pkg.sv =====
// Shared types, constants and helpers for the grid shortest-path search block.
package gasp_pkg;

  localparam int GRID_SIDE  = 16;
  localparam int MAX_GOALS  = 4;
  localparam int HEAP_DEPTH = 1024;

  localparam int CELLS    = GRID_SIDE * GRID_SIDE;
  localparam int AW       = $clog2(CELLS);
  localparam int HW       = $clog2(HEAP_DEPTH);
  localparam int GCW      = $clog2(MAX_GOALS + 1);
  localparam int GIW      = (MAX_GOALS > 1) ? $clog2(MAX_GOALS) : 1;
  localparam int CRD_W    = 5;
  localparam int COST_W   = 9;
  localparam int PATH_DEPTH = 2 * CELLS;

  localparam logic [COST_W-1:0] UNREACHED = '1;
  localparam logic [COST_W-1:0] F_DEAD    = '1;
  localparam logic [4:0]        SIZE_RST  = 5'd16;

  localparam logic [1:0] DIR_N = 2'd0;
  localparam logic [1:0] DIR_E = 2'd1;
  localparam logic [1:0] DIR_S = 2'd2;
  localparam logic [1:0] DIR_W = 2'd3;

  typedef logic [CRD_W-1:0]  crd_t;
  typedef logic [COST_W-1:0] cost_t;

  typedef enum logic [2:0] {
    KIND_WRITE  = 3'd0,
    KIND_GOAL   = 3'd1,
    KIND_CLEAR  = 3'd2,
    KIND_SEARCH = 3'd3,
    KIND_READ   = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    STAT_ACK     = 2'd0,
    STAT_FOUND   = 2'd1,
    STAT_AT_GOAL = 2'd2,
    STAT_NO_PATH = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_MCLR, S_IDLE, S_RDSTEP, S_RESP, S_CHK, S_SRD, S_GOAL, S_GCHK,
    S_CLR, S_INIT, S_POP, S_SCAN, S_TAKE, S_CLCHK, S_CMP, S_NB,
    S_NBCHK, S_TRRD, S_TRWR, S_TDONE, S_NEXT
  } state_e;

  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] cell_x;
    logic [3:0] cell_y;
    logic [3:0] open_sides;
    logic       explored;
    logic [7:0] step_index;
  } req_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] path_length;
    logic [3:0] step_x;
    logic [3:0] step_y;
  } resp_t;

  typedef struct packed {
    logic [4:0] grid_width;
    logic [4:0] grid_height;
  } cfg_t;

  typedef struct packed {
    logic [3:0] sides;
    logic       expl;
  } map_t;

  typedef struct packed {
    cost_t      cost;
    logic [1:0] came;
    logic       closed;
  } scr_t;

  typedef struct packed {
    crd_t  x;
    crd_t  y;
    cost_t g;
    cost_t f;
  } open_t;

  typedef struct packed {
    crd_t x;
    crd_t y;
  } path_t;

  function automatic logic [AW-1:0] cell_addr(crd_t x, crd_t y);
    logic [31:0] a;
    a = 32'(y) * GRID_SIDE + 32'(x);
    return a[AW-1:0];
  endfunction

  function automatic logic [4:0] clamp_size(logic [4:0] v);
    logic [4:0] r;
    r = v;
    if (v == 5'd0) r = 5'd1;
    else if (32'(v) > GRID_SIDE) r = 5'(GRID_SIDE);
    return r;
  endfunction

  function automatic cost_t manhattan(crd_t ax, crd_t ay, crd_t bx, crd_t by);
    crd_t dx;
    crd_t dy;
    dx = (ax > bx) ? ax - bx : bx - ax;
    dy = (ay > by) ? ay - by : by - ay;
    return COST_W'(dx) + COST_W'(dy);
  endfunction

endpackage

// ===== rtl/grid_astar_shortest_path.sv =====
// Top level of the grid shortest-path search block: stream ports, APB port, output register.
//
// Commands arrive as beats on the s_axis channel (kind in tuser): write a map cell,
// add a goal, clear goals, search from a cell, or read one step of the kept path.
// Every command returns exactly one beat on m_axis (status in tuser).
// Grid width and height are set over APB at byte addresses 0 and 4; the user must write
// them only while idle, since the block does not enforce it. Map writes, goal commands
// and unused kinds answer straight from idle; a path step read first reads the path RAM.
// A search checks and reads the start, then for each goal that can be tried sweeps the
// scratch over every cell, then for each cell taken off the open list scans the open list
// (one entry a cycle, up to its fill) and reads and checks each neighbor, then traces
// the path back cell by cell. One command is worked on at a time.
// After reset the map is swept to closed and unexplored, one cell a cycle,
// and s_axis_tready stays low until that ends. A result that the receiver stalls waits
// in the output register; the next command beat is still taken and its own result
// waits inside until the register frees.
module grid_astar_shortest_path import gasp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: cell_x[3:0], cell_y[7:4], open_sides[11:8], explored[12], step_index[20:13]
  input  logic [23:0] s_axis_tdata,
  // tuser: kind[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: path_length[7:0], step_x[11:8], step_y[15:12]
  output logic [15:0] m_axis_tdata,
  // tuser: status[1:0]
  output logic [1:0]  m_axis_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t  cfg;
  req_t  req;
  resp_t resp;
  logic  resp_valid, resp_ready;
  logic  out_valid_q, out_valid_d;
  resp_t out_q;

  gasp_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );

  // Unpack the command beat
  assign req = '{kind: s_axis_tuser, cell_x: s_axis_tdata[3:0], cell_y: s_axis_tdata[7:4],
                 open_sides: s_axis_tdata[11:8], explored: s_axis_tdata[12],
                 step_index: s_axis_tdata[20:13]};

  gasp_engine u_engine (
    .clk_i, .rst_ni, .cfg_i(cfg),
    .req_valid_i(s_axis_tvalid), .req_ready_o(s_axis_tready), .req_i(req),
    .resp_valid_o(resp_valid), .resp_ready_i(resp_ready), .resp_o(resp)
  );

  // Output register: load when empty or being drained
  assign resp_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready) out_valid_d = 1'b0;
    if (resp_valid && resp_ready) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (resp_valid && resp_ready) out_q <= resp;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.step_y, out_q.step_x, out_q.path_length};
  assign m_axis_tuser  = out_q.status;

endmodule

// ===== rtl/gasp_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module gasp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/gasp_cfg.sv =====
// APB register file holding the grid width and height in use.
module gasp_cfg import gasp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  // Decode the write
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      if (paddr[2]) cfg_d.grid_height = pwdata[4:0];
      else cfg_d.grid_width = pwdata[4:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{grid_width: SIZE_RST, grid_height: SIZE_RST};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign prdata = paddr[2] ? {27'd0, cfg_q.grid_height} : {27'd0, cfg_q.grid_width};
  assign cfg_o  = cfg_q;

endmodule

// ===== rtl/gasp_engine.sv =====
// Command sequencer and A* search engine over the map, scratch, open-list and path RAMs.
module gasp_engine import gasp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  req_valid_i,
  output logic  req_ready_o,
  input  req_t  req_i,
  output logic  resp_valid_o,
  input  logic  resp_ready_i,
  output resp_t resp_o
);

  state_e state_q, state_d;
  req_t   req_q, req_d;
  resp_t  resp_q, resp_d;

  logic [3:0]     goal_x_q [MAX_GOALS];
  logic [3:0]     goal_y_q [MAX_GOALS];
  logic [GCW-1:0] goal_cnt_q, goal_cnt_d;
  logic [GCW-1:0] goal_idx_q, goal_idx_d;
  logic           goal_we;

  logic [8:0]  best_len_q, best_len_d;
  logic        bank_q, bank_d;
  logic        start_expl_q, start_expl_d;
  crd_t        gx_q, gx_d, gy_q, gy_d;
  logic [AW:0] cnt_q, cnt_d;

  logic [HW:0]   wr_ptr_q, wr_ptr_d, live_q, live_d;
  logic [HW:0]   scan_idx_q, scan_idx_d, cmp_w_q, cmp_w_d;
  logic          scan_vld_q, scan_vld_d;
  logic [HW-1:0] scan_pos_q, scan_pos_d, best_slot_q, best_slot_d;
  open_t         best_q, best_d;

  crd_t       cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  cost_t      cur_g_q, cur_g_d;
  logic [3:0] cur_sides_q, cur_sides_d;
  logic [1:0] dir_q, dir_d;
  crd_t       nb_x_q, nb_x_d, nb_y_q, nb_y_d;
  crd_t       node_x_q, node_x_d, node_y_q, node_y_d;
  logic [8:0] tr_q, tr_d;

  // RAM ports
  logic          map_we;
  logic [AW-1:0] map_waddr, map_raddr;
  map_t          map_wdata, map_rdata;
  logic          scr_we;
  logic [AW-1:0] scr_waddr, scr_raddr;
  scr_t          scr_wdata, scr_rdata;
  logic          open_we;
  logic [HW-1:0] open_waddr, open_raddr;
  open_t         open_wdata, open_rdata;
  logic          path_we;
  logic [AW:0]   path_waddr, path_raddr;
  path_t         path_wdata, path_rdata;

  // Shared conditions
  crd_t       sx, sy;
  logic [4:0] w_c, h_c;
  logic       at_goal, start_in, goal_ok, cur_is_goal, nb_in, nb_ok, cmp_need;
  logic       last_clr, scan_done;
  logic [9:0] ng;
  logic [7:0] len_sat;

  assign sx  = CRD_W'(req_q.cell_x);
  assign sy  = CRD_W'(req_q.cell_y);
  assign w_c = clamp_size(cfg_i.grid_width);
  assign h_c = clamp_size(cfg_i.grid_height);

  always_comb begin
    at_goal = 1'b0;
    for (int i = 0; i < MAX_GOALS; i++) begin
      if (GCW'(i) < goal_cnt_q && goal_x_q[i] == req_q.cell_x
          && goal_y_q[i] == req_q.cell_y) at_goal = 1'b1;
    end
  end

  assign start_in    = (sx < CRD_W'(w_c)) && (sy < CRD_W'(h_c));
  assign goal_ok     = (gx_q < CRD_W'(w_c)) && (gy_q < CRD_W'(h_c)) && map_rdata.expl
                       && start_expl_q && !(gx_q == sx && gy_q == sy);
  assign cur_is_goal = (best_q.x == gx_q) && (best_q.y == gy_q);
  assign cmp_need    = (wr_ptr_q > (HW+1)'(HEAP_DEPTH - 4)) && (wr_ptr_q != live_q);
  assign last_clr    = (cnt_q == (AW+1)'(CELLS - 1));
  assign scan_done   = (scan_idx_q >= wr_ptr_q) && !scan_vld_q;
  assign ng          = {1'b0, cur_g_q} + 10'd1;
  assign len_sat     = (best_len_q > 9'd255) ? 8'd255 : best_len_q[7:0];

  // Neighbor in the grid and reachable through an open side
  always_comb begin
    case (dir_q)
      DIR_N:   nb_in = ({1'b0, cur_y_q} + 6'd1) < {1'b0, h_c};
      DIR_E:   nb_in = ({1'b0, cur_x_q} + 6'd1) < {1'b0, w_c};
      DIR_S:   nb_in = (cur_y_q != '0);
      default: nb_in = (cur_x_q != '0);
    endcase
  end
  assign nb_ok = nb_in && cur_sides_q[dir_q];

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_MCLR:   if (last_clr) state_d = S_IDLE;
      S_IDLE: begin
        if (req_valid_i) begin
          case (req_i.kind)
            KIND_SEARCH: state_d = S_CHK;
            KIND_READ:   state_d = S_RDSTEP;
            default:     state_d = S_RESP;
          endcase
        end
      end
      S_RDSTEP: state_d = S_RESP;
      S_RESP:   if (resp_ready_i) state_d = S_IDLE;
      S_CHK:    state_d = (at_goal || !start_in) ? S_RESP : S_SRD;
      S_SRD:    state_d = S_GOAL;
      S_GOAL:   state_d = (goal_idx_q >= goal_cnt_q) ? S_RESP : S_GCHK;
      S_GCHK:   state_d = goal_ok ? S_CLR : S_NEXT;
      S_CLR:    if (last_clr) state_d = S_INIT;
      S_INIT:   state_d = S_POP;
      S_POP:    state_d = (live_q == '0) ? S_NEXT : S_SCAN;
      S_SCAN:   if (scan_done) state_d = S_TAKE;
      S_TAKE:   state_d = cur_is_goal ? S_TRRD : S_CLCHK;
      S_CLCHK: begin
        if (scr_rdata.closed) state_d = S_POP;
        else state_d = cmp_need ? S_CMP : S_NB;
      end
      S_CMP:    if (scan_done) state_d = S_NB;
      S_NB: begin
        if (nb_ok) state_d = S_NBCHK;
        else if (dir_q == DIR_W) state_d = S_POP;
      end
      S_NBCHK:  state_d = (dir_q == DIR_W) ? S_POP : S_NB;
      S_TRRD:   state_d = S_TRWR;
      S_TRWR:   state_d = (tr_q == 9'd1) ? S_TDONE : S_TRRD;
      S_TDONE:  state_d = S_NEXT;
      S_NEXT:   state_d = S_GOAL;
      default:  state_d = S_IDLE;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    logic [31:0] idx32;
    logic [31:0] pos32;
    crd_t        gxs, gys;
    idx32 = 32'(req_i.step_index);
    pos32 = 32'(tr_q) - 32'd1;
    gxs = CRD_W'(goal_x_q[goal_idx_q[GIW-1:0]]);
    gys = CRD_W'(goal_y_q[goal_idx_q[GIW-1:0]]);

    req_d        = req_q;
    resp_d       = resp_q;
    goal_cnt_d   = goal_cnt_q;
    goal_idx_d   = goal_idx_q;
    goal_we      = 1'b0;
    best_len_d   = best_len_q;
    bank_d       = bank_q;
    start_expl_d = start_expl_q;
    gx_d         = gx_q;
    gy_d         = gy_q;
    cnt_d        = cnt_q;
    wr_ptr_d     = wr_ptr_q;
    live_d       = live_q;
    scan_idx_d   = scan_idx_q;
    scan_vld_d   = scan_vld_q;
    scan_pos_d   = scan_pos_q;
    cmp_w_d      = cmp_w_q;
    best_slot_d  = best_slot_q;
    best_d       = best_q;
    cur_x_d      = cur_x_q;
    cur_y_d      = cur_y_q;
    cur_g_d      = cur_g_q;
    cur_sides_d  = cur_sides_q;
    dir_d        = dir_q;
    nb_x_d       = nb_x_q;
    nb_y_d       = nb_y_q;
    node_x_d     = node_x_q;
    node_y_d     = node_y_q;
    tr_d         = tr_q;

    req_ready_o  = 1'b0;
    resp_valid_o = 1'b0;
    map_we = 1'b0; map_waddr = '0; map_wdata = '0; map_raddr = '0;
    scr_we = 1'b0; scr_waddr = '0; scr_wdata = '0; scr_raddr = '0;
    open_we = 1'b0; open_waddr = '0; open_wdata = '0; open_raddr = '0;
    path_we = 1'b0; path_waddr = '0; path_wdata = '0;
    path_raddr = {bank_q, idx32[AW-1:0]};

    case (state_q)
      // Sweep the map to its reset value
      S_MCLR: begin
        map_we    = 1'b1;
        map_waddr = cnt_q[AW-1:0];
        cnt_d     = last_clr ? '0 : cnt_q + 1'b1;
      end

      // Take a command beat
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          req_d  = req_i;
          resp_d = '{status: STAT_ACK, path_length: len_sat, step_x: 4'd0, step_y: 4'd0};
          case (req_i.kind)
            KIND_WRITE: begin
              if (32'(req_i.cell_x) < GRID_SIDE && 32'(req_i.cell_y) < GRID_SIDE) begin
                map_we    = 1'b1;
                map_waddr = cell_addr(CRD_W'(req_i.cell_x), CRD_W'(req_i.cell_y));
                map_wdata = '{sides: req_i.open_sides, expl: req_i.explored};
              end
            end
            KIND_GOAL: begin
              if (goal_cnt_q < GCW'(MAX_GOALS)) begin
                goal_we    = 1'b1;
                goal_cnt_d = goal_cnt_q + 1'b1;
              end
            end
            KIND_CLEAR: goal_cnt_d = '0;
            default: ;
          endcase
        end
      end

      // Return the stored path step
      S_RDSTEP: begin
        if (9'(req_q.step_index) < best_len_q && 32'(req_q.step_index) < CELLS) begin
          resp_d.step_x = path_rdata.x[3:0];
          resp_d.step_y = path_rdata.y[3:0];
        end
      end

      S_RESP: resp_valid_o = 1'b1;

      // Start check and read of the start cell
      S_CHK: begin
        best_len_d = '0;
        goal_idx_d = '0;
        map_raddr  = cell_addr(sx, sy);
        if (at_goal) resp_d = '{status: STAT_AT_GOAL, path_length: 8'd0,
                                 step_x: 4'd0, step_y: 4'd0};
        else if (!start_in) resp_d = '{status: STAT_NO_PATH, path_length: 8'd0,
                                        step_x: 4'd0, step_y: 4'd0};
      end

      S_SRD: start_expl_d = map_rdata.expl;

      // Pick the next goal or finish
      S_GOAL: begin
        gx_d      = gxs;
        gy_d      = gys;
        map_raddr = cell_addr(gxs, gys);
        if (goal_idx_q >= goal_cnt_q) begin
          resp_d = '{status: (best_len_q != '0) ? STAT_FOUND : STAT_NO_PATH,
                     path_length: len_sat, step_x: 4'd0, step_y: 4'd0};
        end
      end

      S_GCHK: cnt_d = '0;

      // Reset the per-search scratch
      S_CLR: begin
        scr_we    = 1'b1;
        scr_waddr = cnt_q[AW-1:0];
        scr_wdata = '{cost: UNREACHED, came: DIR_N, closed: 1'b0};
        cnt_d     = last_clr ? '0 : cnt_q + 1'b1;
      end

      // Seed the open list with the start
      S_INIT: begin
        scr_we     = 1'b1;
        scr_waddr  = cell_addr(sx, sy);
        scr_wdata  = '{cost: '0, came: DIR_N, closed: 1'b0};
        open_we    = 1'b1;
        open_waddr = '0;
        open_wdata = '{x: sx, y: sy, g: '0, f: manhattan(sx, sy, gx_q, gy_q)};
        wr_ptr_d   = (HW+1)'(1);
        live_d     = (HW+1)'(1);
      end

      S_POP: begin
        scan_idx_d = '0;
        scan_vld_d = 1'b0;
        best_d.f   = F_DEAD;
      end

      // Scan the open list for the earliest lowest f
      S_SCAN: begin
        open_raddr = scan_idx_q[HW-1:0];
        scan_pos_d = scan_idx_q[HW-1:0];
        if (scan_idx_q < wr_ptr_q) begin
          scan_vld_d = 1'b1;
          scan_idx_d = scan_idx_q + 1'b1;
        end else begin
          scan_vld_d = 1'b0;
        end
        if (scan_vld_q && open_rdata.f != F_DEAD && open_rdata.f < best_q.f) begin
          best_d      = open_rdata;
          best_slot_d = scan_pos_q;
        end
      end

      // Remove the chosen entry
      S_TAKE: begin
        open_we    = 1'b1;
        open_waddr = best_slot_q;
        open_wdata = '{x: best_q.x, y: best_q.y, g: best_q.g, f: F_DEAD};
        live_d     = live_q - 1'b1;
        cur_x_d    = best_q.x;
        cur_y_d    = best_q.y;
        cur_g_d    = best_q.g;
        node_x_d   = best_q.x;
        node_y_d   = best_q.y;
        tr_d       = best_q.g;
        scr_raddr  = cell_addr(best_q.x, best_q.y);
        map_raddr  = cell_addr(best_q.x, best_q.y);
      end

      // Close the current cell
      S_CLCHK: begin
        dir_d       = DIR_N;
        cur_sides_d = map_rdata.sides;
        scan_idx_d  = '0;
        scan_vld_d  = 1'b0;
        cmp_w_d     = '0;
        if (!scr_rdata.closed) begin
          scr_we    = 1'b1;
          scr_waddr = cell_addr(cur_x_q, cur_y_q);
          scr_wdata = '{cost: scr_rdata.cost, came: scr_rdata.came, closed: 1'b1};
        end
      end

      // Squeeze out removed entries, keeping order
      S_CMP: begin
        open_raddr = scan_idx_q[HW-1:0];
        if (scan_idx_q < wr_ptr_q) begin
          scan_vld_d = 1'b1;
          scan_idx_d = scan_idx_q + 1'b1;
        end else begin
          scan_vld_d = 1'b0;
        end
        if (scan_vld_q && open_rdata.f != F_DEAD) begin
          open_we    = 1'b1;
          open_waddr = cmp_w_q[HW-1:0];
          open_wdata = open_rdata;
          cmp_w_d    = cmp_w_q + 1'b1;
        end
        if (scan_done) wr_ptr_d = cmp_w_q;
      end

      // Issue reads of the next neighbor
      S_NB: begin
        case (dir_q)
          DIR_N:   begin nb_x_d = cur_x_q;        nb_y_d = cur_y_q + 1'b1; end
          DIR_E:   begin nb_x_d = cur_x_q + 1'b1; nb_y_d = cur_y_q;        end
          DIR_S:   begin nb_x_d = cur_x_q;        nb_y_d = cur_y_q - 1'b1; end
          default: begin nb_x_d = cur_x_q - 1'b1; nb_y_d = cur_y_q;        end
        endcase
        map_raddr = cell_addr(nb_x_d, nb_y_d);
        scr_raddr = cell_addr(nb_x_d, nb_y_d);
        if (!nb_ok) dir_d = dir_q + 1'b1;
      end

      // Relax the neighbor and push it
      S_NBCHK: begin
        dir_d = dir_q + 1'b1;
        if (map_rdata.expl && !scr_rdata.closed && ng < {1'b0, scr_rdata.cost}) begin
          scr_we    = 1'b1;
          scr_waddr = cell_addr(nb_x_q, nb_y_q);
          scr_wdata = '{cost: ng[COST_W-1:0], came: dir_q + 2'd2, closed: 1'b0};
          if (live_q < (HW+1)'(HEAP_DEPTH)) begin
            open_we    = 1'b1;
            open_waddr = wr_ptr_q[HW-1:0];
            open_wdata = '{x: nb_x_q, y: nb_y_q, g: ng[COST_W-1:0],
                           f: ng[COST_W-1:0] + manhattan(nb_x_q, nb_y_q, gx_q, gy_q)};
            wr_ptr_d   = wr_ptr_q + 1'b1;
            live_d     = live_q + 1'b1;
          end
        end
      end

      // Walk parents back from the goal into the spare bank
      S_TRRD: scr_raddr = cell_addr(node_x_q, node_y_q);

      S_TRWR: begin
        path_we    = 1'b1;
        path_waddr = {~bank_q, pos32[AW-1:0]};
        path_wdata = '{x: node_x_q, y: node_y_q};
        tr_d       = tr_q - 1'b1;
        case (scr_rdata.came)
          DIR_N:   node_y_d = node_y_q + 1'b1;
          DIR_E:   node_x_d = node_x_q + 1'b1;
          DIR_S:   node_y_d = node_y_q - 1'b1;
          default: node_x_d = node_x_q - 1'b1;
        endcase
      end

      // Keep the shorter path
      S_TDONE: begin
        if (best_len_q == '0 || cur_g_q < best_len_q) begin
          bank_d     = ~bank_q;
          best_len_d = cur_g_q;
        end
      end

      S_NEXT: goal_idx_d = goal_idx_q + 1'b1;

      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_MCLR;
      cnt_q      <= '0;
      goal_cnt_q <= '0;
      best_len_q <= '0;
      bank_q     <= 1'b0;
      scan_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      goal_cnt_q <= goal_cnt_d;
      best_len_q <= best_len_d;
      bank_q     <= bank_d;
      scan_vld_q <= scan_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    resp_q       <= resp_d;
    goal_idx_q   <= goal_idx_d;
    start_expl_q <= start_expl_d;
    gx_q         <= gx_d;
    gy_q         <= gy_d;
    wr_ptr_q     <= wr_ptr_d;
    live_q       <= live_d;
    scan_idx_q   <= scan_idx_d;
    scan_pos_q   <= scan_pos_d;
    cmp_w_q      <= cmp_w_d;
    best_slot_q  <= best_slot_d;
    best_q       <= best_d;
    cur_x_q      <= cur_x_d;
    cur_y_q      <= cur_y_d;
    cur_g_q      <= cur_g_d;
    cur_sides_q  <= cur_sides_d;
    dir_q        <= dir_d;
    nb_x_q       <= nb_x_d;
    nb_y_q       <= nb_y_d;
    node_x_q     <= node_x_d;
    node_y_q     <= node_y_d;
    tr_q         <= tr_d;
    if (goal_we) begin
      goal_x_q[goal_cnt_q[GIW-1:0]] <= req_i.cell_x;
      goal_y_q[goal_cnt_q[GIW-1:0]] <= req_i.cell_y;
    end
  end

  assign resp_o = resp_q;

  gasp_ram #(.WIDTH($bits(map_t)), .DEPTH(CELLS)) u_map (
    .clk_i, .we_i(map_we), .waddr_i(map_waddr), .wdata_i(map_wdata),
    .raddr_i(map_raddr), .rdata_o(map_rdata)
  );

  gasp_ram #(.WIDTH($bits(scr_t)), .DEPTH(CELLS)) u_scr (
    .clk_i, .we_i(scr_we), .waddr_i(scr_waddr), .wdata_i(scr_wdata),
    .raddr_i(scr_raddr), .rdata_o(scr_rdata)
  );

  gasp_ram #(.WIDTH($bits(open_t)), .DEPTH(HEAP_DEPTH)) u_open (
    .clk_i, .we_i(open_we), .waddr_i(open_waddr), .wdata_i(open_wdata),
    .raddr_i(open_raddr), .rdata_o(open_rdata)
  );

  gasp_ram #(.WIDTH($bits(path_t)), .DEPTH(PATH_DEPTH)) u_path (
    .clk_i, .we_i(path_we), .waddr_i(path_waddr), .wdata_i(path_wdata),
    .raddr_i(path_raddr), .rdata_o(path_rdata)
  );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the grid shortest-path search block.
module testbench;
  import gasp_pkg::*;

  localparam logic [2:0] KIND_SPARE_LO = 3'd5;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;
  localparam int         REG_WIDTH     = 0;
  localparam int         REG_HEIGHT    = 1;
  localparam int         NO_COST       = 511;

  typedef struct {
    logic [2:0] kind;
    logic [3:0] x;
    logic [3:0] y;
    logic [3:0] sides;
    logic       expl;
    logic [7:0] idx;
    bit         typed;
    status_e    status;
    logic [7:0] len;
  } row_t;

  typedef struct {
    status_e    status;
    logic [7:0] len;
    logic [3:0] sx;
    logic [3:0] sy;
  } beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  grid_astar_shortest_path i_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Mirror of the block state
  logic [4:0] cfg_w = 5'd16, cfg_h = 5'd16;
  logic [3:0] side_map[256];
  bit         expl_map[256];
  int         goal_xs[MAX_GOALS], goal_ys[MAX_GOALS];
  int         goal_n;
  int         kept_len;
  int         kept_x[256], kept_y[256];
  // Per-search scratch
  int         cost[256], came[256], cand_x[256], cand_y[256];
  bit         closed[256];
  int         ol_cell[HEAP_DEPTH], ol_g[HEAP_DEPTH], ol_f[HEAP_DEPTH];
  int         ol_n;

  beat_t      pending_beats[$];
  int         mismatches = 0;
  int         sent = 0;
  bit         quiet = 1'b0;
  bit         calm = 1'b0;

  function automatic int adiff(int a, int b);
    return a > b ? a - b : b - a;
  endfunction

  function automatic int clamp_dim(logic [4:0] v);
    if (v == 0) return 1;
    if (v > 16) return 16;
    return v;
  endfunction

  function automatic void ol_push(int c, int g, int f);
    if (ol_n >= HEAP_DEPTH) return;
    ol_cell[ol_n] = c;
    ol_g[ol_n] = g;
    ol_f[ol_n] = f;
    ol_n++;
  endfunction

  // Unit-cost A* over explored cells; returns the path length and leaves the path in cand_x/cand_y
  function automatic int path_search(int sx, int sy, int ex, int ey, int w, int h);
    int start, goal, pick, cur, g, cx, cy, nx, ny, nb, node, n, t;
    start = sy * 16 + sx;
    goal = ey * 16 + ex;
    if (!expl_map[start] || !expl_map[goal] || start == goal) return 0;
    for (int i = 0; i < 256; i++) begin
      cost[i] = NO_COST;
      closed[i] = 1'b0;
      came[i] = 0;
    end
    ol_n = 0;
    cost[start] = 0;
    ol_push(start, 0, adiff(sx, ex) + adiff(sy, ey));
    while (ol_n > 0) begin
      pick = 0;
      for (int i = 1; i < ol_n; i++) if (ol_f[i] < ol_f[pick]) pick = i;
      cur = ol_cell[pick];
      g = ol_g[pick];
      for (int i = pick; i < ol_n - 1; i++) begin
        ol_cell[i] = ol_cell[i+1];
        ol_g[i] = ol_g[i+1];
        ol_f[i] = ol_f[i+1];
      end
      ol_n--;
      if (cur == goal) begin
        // walk parents back to the start, then reverse
        n = 0;
        node = goal;
        while (node != start && n < 256) begin
          nx = node % 16;
          ny = node / 16;
          cand_x[n] = nx;
          cand_y[n] = ny;
          n++;
          case (came[node])
            DIR_N: ny++;
            DIR_E: nx++;
            DIR_S: ny--;
            default: nx--;
          endcase
          if (nx < 0 || ny < 0 || nx >= 16 || ny >= 16) return 0;
          node = ny * 16 + nx;
        end
        if (node != start) return 0;
        for (int i = 0; i < n / 2; i++) begin
          t = cand_x[i]; cand_x[i] = cand_x[n-1-i]; cand_x[n-1-i] = t;
          t = cand_y[i]; cand_y[i] = cand_y[n-1-i]; cand_y[n-1-i] = t;
        end
        return n;
      end
      if (closed[cur]) continue;
      closed[cur] = 1'b1;
      cx = cur % 16;
      cy = cur / 16;
      for (int d = 0; d < 4; d++) begin
        nx = cx + ((d == DIR_E) ? 1 : (d == DIR_W) ? -1 : 0);
        ny = cy + ((d == DIR_N) ? 1 : (d == DIR_S) ? -1 : 0);
        if (nx < 0 || ny < 0 || nx >= w || ny >= h) continue;
        nb = ny * 16 + nx;
        if (!expl_map[nb] || closed[nb]) continue;
        if (!side_map[cur][d]) continue;
        if (g + 1 < cost[nb]) begin
          cost[nb] = g + 1;
          came[nb] = (d + 2) % 4;
          ol_push(nb, g + 1, g + 1 + adiff(nx, ex) + adiff(ny, ey));
        end
      end
    end
    return 0;
  endfunction

  // Apply one command to the mirror and return the beat it should produce
  function automatic beat_t predict_command(row_t r);
    beat_t b;
    bit    hit;
    int    w, h, n;
    b.status = STAT_ACK;
    b.sx = '0;
    b.sy = '0;
    case (r.kind)
      KIND_WRITE: begin
        side_map[r.y * 16 + r.x] = r.sides;
        expl_map[r.y * 16 + r.x] = r.expl;
      end
      KIND_GOAL: if (goal_n < MAX_GOALS) begin
        goal_xs[goal_n] = r.x;
        goal_ys[goal_n] = r.y;
        goal_n++;
      end
      KIND_CLEAR: goal_n = 0;
      KIND_SEARCH: begin
        hit = 1'b0;
        for (int i = 0; i < goal_n; i++)
          if (goal_xs[i] == r.x && goal_ys[i] == r.y) hit = 1'b1;
        kept_len = 0;
        if (hit) begin
          b.status = STAT_AT_GOAL;
        end else begin
          w = clamp_dim(cfg_w);
          h = clamp_dim(cfg_h);
          if (r.x < w && r.y < h) begin
            for (int i = 0; i < goal_n; i++) begin
              if (goal_xs[i] >= w || goal_ys[i] >= h) continue;
              if (!expl_map[goal_ys[i] * 16 + goal_xs[i]]) continue;
              n = path_search(r.x, r.y, goal_xs[i], goal_ys[i], w, h);
              if (n > 0 && (kept_len == 0 || n < kept_len)) begin
                for (int k = 0; k < n; k++) begin
                  kept_x[k] = cand_x[k];
                  kept_y[k] = cand_y[k];
                end
                kept_len = n;
              end
            end
          end
          b.status = kept_len > 0 ? STAT_FOUND : STAT_NO_PATH;
        end
      end
      KIND_READ: if (r.idx < kept_len) begin
        b.sx = kept_x[r.idx];
        b.sy = kept_y[r.idx];
      end
      default: ;
    endcase
    b.len = kept_len > 255 ? 8'd255 : kept_len[7:0];
    return b;
  endfunction

  // Drive one command beat, hold it until taken, then queue its result
  task automatic send_cmd(row_t r);
    beat_t b;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= r.kind;
    s_axis_tdata <= {3'b0, r.idx, r.expl, r.sides, r.y, r.x};
    do @(posedge clk_i); while (!s_axis_tready);
    b = predict_command(r);
    if (r.typed) begin
      b.status = r.status;
      b.len = r.len;
      b.sx = '0;
      b.sy = '0;
    end
    pending_beats.insert(pending_beats.size(), b);
    sent++;
    if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
  endtask

  task automatic cmd(logic [2:0] k, int x, int y, int sides = 0, int expl = 0, int idx = 0);
    row_t r;
    r = '{k, x[3:0], y[3:0], sides[3:0], expl[0], idx[7:0], 1'b0, STAT_ACK, 8'd0};
    send_cmd(r);
  endtask

  task automatic reg_write(int index, logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(4 * index);
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (index == REG_WIDTH) cfg_w = value[4:0];
    else cfg_h = value[4:0];
  endtask

  // Wait for every result, then let the block settle before touching registers
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_size();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'd31;
      2: return 32'd16;
      3: return 32'd1;
      4: return $urandom;
      default: return $urandom_range(2, 8);
    endcase
  endfunction

  // Result side: random stall bursts, none in the final stretch
  int ready_left = 0;
  always @(posedge clk_i) begin
    if (quiet) begin
      m_axis_tready <= 1'b1;
    end else if (ready_left == 0) begin
      m_axis_tready <= $urandom_range(0, 1);
      ready_left <= $urandom_range(1, 14);
    end else begin
      ready_left <= ready_left - 1;
    end
  end

  // Compare each accepted result beat with the oldest expectation
  always @(posedge clk_i) begin
    beat_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h/%h", m_axis_tuser, m_axis_tdata);
      end else begin
        e = pending_beats.pop_front();
        if (m_axis_tuser != e.status || m_axis_tdata[7:0] != e.len ||
            m_axis_tdata[11:8] != e.sx || m_axis_tdata[15:12] != e.sy) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected st=%0d len=%0d x=%0d y=%0d, got st=%0d len=%0d x=%0d y=%0d",
                     e.status, e.len, e.sx, e.sy, m_axis_tuser, m_axis_tdata[7:0],
                     m_axis_tdata[11:8], m_axis_tdata[15:12]);
        end
      end
    end
  end

  row_t directed[] = '{
    '{KIND_READ,     0,  0, 0, 0,   0, 1, STAT_ACK,     0},
    '{KIND_SEARCH,   0,  0, 0, 0,   0, 1, STAT_NO_PATH, 0},
    '{KIND_SPARE_LO, 9,  9, 15, 1, 255, 1, STAT_ACK,    0},
    '{KIND_SPARE_HI, 15, 15, 15, 1, 255, 1, STAT_ACK,   0},
    '{KIND_WRITE,    0,  0, 15, 1,  0, 1, STAT_ACK,     0},
    '{KIND_WRITE,    1,  0, 15, 1,  0, 0, STAT_ACK,     0},
    '{KIND_WRITE,    2,  0, 15, 1,  0, 0, STAT_ACK,     0},
    '{KIND_WRITE,    2,  1, 15, 1,  0, 0, STAT_ACK,     0},
    '{KIND_GOAL,     2,  1, 0, 0,   0, 1, STAT_ACK,     0},
    '{KIND_SEARCH,   0,  0, 0, 0,   0, 0, STAT_ACK,     0},
    '{KIND_READ,     0,  0, 0, 0,   0, 0, STAT_ACK,     0},
    '{KIND_READ,     0,  0, 0, 0,   2, 0, STAT_ACK,     0},
    '{KIND_READ,     0,  0, 0, 0, 255, 0, STAT_ACK,     0},
    '{KIND_GOAL,     0,  0, 0, 0,   0, 0, STAT_ACK,     0},
    '{KIND_SEARCH,   0,  0, 0, 0,   0, 1, STAT_AT_GOAL, 0},
    '{KIND_CLEAR,    0,  0, 0, 0,   0, 1, STAT_ACK,     0},
    '{KIND_GOAL,    15, 15, 0, 0,   0, 0, STAT_ACK,     0},
    '{KIND_GOAL,     1,  0, 0, 0,   0, 0, STAT_ACK,     0},
    '{KIND_GOAL,     2,  1, 0, 0,   0, 0, STAT_ACK,     0},
    '{KIND_GOAL,     2,  0, 0, 0,   0, 0, STAT_ACK,     0},
    '{KIND_GOAL,     0,  0, 0, 0,   0, 0, STAT_ACK,     0},
    '{KIND_SEARCH,   0,  0, 0, 0,   0, 0, STAT_ACK,     0},
    '{KIND_SEARCH,  15, 15, 0, 0,   0, 1, STAT_AT_GOAL, 0},
    '{KIND_SEARCH,   5,  5, 0, 0,   0, 1, STAT_NO_PATH, 0},
    '{KIND_WRITE,   15, 15, 0, 0, 255, 0, STAT_ACK,     0}
  };

  initial begin
    int w, h, gx, gy;
    for (int i = 0; i < 256; i++) begin
      side_map[i] = '0;
      expl_map[i] = 1'b0;
    end
    goal_n = 0;
    kept_len = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i]) send_cmd(directed[i]);

    // Random phases: new size, grow the maze, set goals, search and read back
    while (sent < 950) begin
      drain();
      reg_write(REG_WIDTH, pick_size());
      reg_write(REG_HEIGHT, pick_size());
      quiet = sent >= 850;
      calm = $urandom_range(0, 3) == 0;
      w = clamp_dim(cfg_w);
      h = clamp_dim(cfg_h);
      repeat ($urandom_range(6, 20))
        cmd(KIND_WRITE, $urandom_range(0, w - 1), $urandom_range(0, h - 1),
            $urandom_range(0, 15) | $urandom_range(0, 15), $urandom_range(0, 7) != 0,
            $urandom_range(0, 255));
      if ($urandom_range(0, 2) != 0) cmd(KIND_CLEAR, $urandom, $urandom, $urandom, $urandom,
                                          $urandom);
      repeat ($urandom_range(1, 5)) begin
        gx = $urandom_range(0, 9) == 0 ? $urandom_range(0, 15) : $urandom_range(0, w - 1);
        gy = $urandom_range(0, 9) == 0 ? $urandom_range(0, 15) : $urandom_range(0, h - 1);
        cmd(KIND_GOAL, gx, gy, $urandom, $urandom, $urandom);
      end
      repeat (2) begin
        gx = $urandom_range(0, 9) == 0 ? $urandom_range(0, 15) : $urandom_range(0, w - 1);
        gy = $urandom_range(0, 9) == 0 ? $urandom_range(0, 15) : $urandom_range(0, h - 1);
        cmd(KIND_SEARCH, gx, gy, $urandom, $urandom, $urandom);
        repeat ($urandom_range(1, 4))
          cmd(KIND_READ, $urandom, $urandom, $urandom, $urandom,
              $urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 8));
      end
      // noise: any kind, any field values
      repeat ($urandom_range(0, 3))
        cmd($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Hard stop for a hung run
  initial begin
    repeat (200) #20000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/gasp_pkg.sv
rtl/gasp_ram.sv
rtl/gasp_cfg.sv
rtl/gasp_engine.sv
rtl/grid_astar_shortest_path.sv
tb/testbench.sv
